// ===== design/soa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types, codes and helpers of the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int ADDR_W    = 48;
  localparam int REQ_W     = 12;
  localparam int ALIGN_W   = 4;
  localparam int OSIZE_W   = 16;
  localparam int HELD_W    = 17;
  localparam int STATUS_W  = 3;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MIN_OBJ   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_REAP  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_NO_MEM  = 3'd1,
    STAT_DOUBLE  = 3'd2,
    STAT_BAD     = 3'd3,
    STAT_NO_REAP = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    TAG_NONE    = 2'd0,
    TAG_FULL    = 2'd1,
    TAG_PARTIAL = 2'd2,
    TAG_EMPTY   = 2'd3
  } tag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REQ_SIZE  = 2'd0,
    REG_ALIGN     = 2'd1,
    REG_POOL_BASE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    UOP_MUL = 1'b0,
    UOP_DIV = 1'b1
  } uop_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NDIV,
    S_PICK,
    S_SCAN,
    S_FILL,
    S_SRD,
    S_SWAIT,
    S_MUL,
    S_FCHK,
    S_FDIV,
    S_FWAIT
  } state_t;

  typedef struct packed {
    logic push;
    logic remove;
  } q_ctl_t;

  // size raised to the minimum, then rounded up to the alignment
  function automatic logic [OSIZE_W-1:0] obj_size(input logic [REQ_W-1:0] req,
                                                  input logic [ALIGN_W-1:0] al);
    logic [OSIZE_W-1:0] s;
    logic [OSIZE_W-1:0] msk;
    s   = (req < REQ_W'(MIN_OBJ)) ? OSIZE_W'(MIN_OBJ) : OSIZE_W'(req);
    msk = (OSIZE_W'(1) << al) - OSIZE_W'(1);
    return (s + msk) & ~msk;
  endfunction

endpackage

// ===== design/slab_object_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_object_allocator
// Slab allocator for one object cache over a pool of equal pages.
// ----------------------------------------------------------------------------
// Commands enter on start/cmd/may_grow/object_addr and are taken when start
// is high and busy is low. Each item gives exactly one result: done is high
// for one cycle with status, result_addr and bytes_held; the receiver takes
// it in that cycle and cannot hold it off. A new item may start in the same
// cycle that done is shown.
// Reap and the unused command finish in the cycle after they are taken.
// Allocate and free first find the objects per slab with the shared
// bit-serial divide/multiply unit (PGW+1 bits wide, PGW = log2 PAGE_BYTES),
// then run a second pass of the same unit (multiply for the object offset,
// divide for the freed offset). An allocate that grows a page adds a scan of
// up to NUM_PAGES pages and a stack fill of one object a cycle.
// The per-page stack and free-flag stores have one write and one read port
// and a registered read; the free flags need no clearing pass, since an
// entry is always written by a page grow before it can be read.
// Reset empties the cache, loads default geometry and holds no pages.
// Configuration writes are dropped while any page is held.
// ----------------------------------------------------------------------------
module slab_object_allocator #(
  parameter int NUM_PAGES    = 16,
  parameter int PAGE_BYTES   = 4096,
  parameter int MAX_OBJS     = 512,
  parameter int HEADER_BYTES = 40
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [soa_pkg::CMD_W-1:0]          cmd,
  input  logic                               may_grow,
  input  logic [soa_pkg::ADDR_W-1:0]         object_addr,
  output logic                               done,
  output logic [soa_pkg::STATUS_W-1:0]       status,
  output logic [soa_pkg::ADDR_W-1:0]         result_addr,
  output logic [soa_pkg::HELD_W-1:0]         bytes_held,
  input  logic                               cfg_we,
  input  logic [soa_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [soa_pkg::ADDR_W-1:0]         cfg_wdata
);

  localparam int PGW   = $clog2(PAGE_BYTES);
  localparam int AW    = PGW + 1;
  localparam int PIW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int KW    = $clog2(MAX_OBJS);
  localparam int NW    = $clog2(MAX_OBJS + 1);
  localparam int CW    = $clog2(NUM_PAGES + 1);
  localparam int MAW   = PIW + KW;
  localparam int MDEPTH = NUM_PAGES * (1 << KW);
  localparam int CMPW  = (AW > NW) ? AW : NW;
  localparam int SLAB_BYTES = PAGE_BYTES - HEADER_BYTES;
  localparam logic [soa_pkg::ADDR_W-1:0] SPAN =
    soa_pkg::ADDR_W'(NUM_PAGES * PAGE_BYTES);

  // configuration
  logic [soa_pkg::REQ_W-1:0]   req_size;
  logic [soa_pkg::ALIGN_W-1:0] align_log2;
  logic [soa_pkg::ADDR_W-1:0]  pool_base;
  logic [soa_pkg::OSIZE_W-1:0] s_obj;

  // sequencer registers
  soa_pkg::state_t             state, state_next;
  logic [soa_pkg::CMD_W-1:0]   cmd_r, cmd_r_next;
  logic                        grow_r, grow_r_next;
  logic [soa_pkg::ADDR_W-1:0]  oaddr, oaddr_next;
  logic [PIW-1:0]              pg, pg_next;
  logic [KW-1:0]               kk, kk_next;
  logic [NW-1:0]               n_r, n_r_next;
  logic                        done_r, done_r_next;
  soa_pkg::status_t            status_r, status_r_next;
  logic [soa_pkg::ADDR_W-1:0]  raddr, raddr_next;

  // page state
  logic [NUM_PAGES-1:0]        page_owned;
  soa_pkg::tag_t               page_tag [NUM_PAGES];
  logic [NW-1:0]               page_cnt [NUM_PAGES];
  logic [CW-1:0]               owned_cnt;

  // page array write controls
  logic [PIW-1:0]              pa_page;
  logic                        pa_set, pa_clr, pc_we;
  logic [NW-1:0]               pc_wdata;
  logic                        rq_en;
  soa_pkg::tag_t               rq_tag;
  logic                        oc_inc, oc_dec;

  // queues
  soa_pkg::q_ctl_t             pq_ctl, eq_ctl;
  logic [PIW-1:0]              pq_head, eq_head;
  logic [CW-1:0]               pq_cnt, eq_cnt;

  // shared unit
  logic                        u_start, u_done;
  soa_pkg::uop_t               u_op;
  logic [AW-1:0]               u_a, u_quo, u_prod;
  logic [soa_pkg::OSIZE_W-1:0] u_rem;

  // memories
  logic [KW-1:0]               stack_mem [MDEPTH];
  logic                        st_we;
  logic [MAW-1:0]              st_waddr, st_raddr;
  logic [KW-1:0]               st_wdata, st_rdata;
  logic                        free_mem [MDEPTH];
  logic                        fm_we, fm_wdata, fm_rdata;
  logic [MAW-1:0]              fm_waddr, fm_raddr;

  // scratch
  logic [soa_pkg::ADDR_W:0]    rel;
  logic [NW-1:0]               cnt_cur;

  assign s_obj   = soa_pkg::obj_size(req_size, align_log2);
  assign cnt_cur = page_cnt[pg];
  assign rel     = {1'b0, oaddr} - {1'b0, pool_base};

  soa_shift_unit #(
    .AW (AW),
    .SW (soa_pkg::OSIZE_W)
  ) u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (u_start),
    .op    (u_op),
    .a     (u_a),
    .b     (s_obj),
    .done  (u_done),
    .quo   (u_quo),
    .rem   (u_rem),
    .prod  (u_prod)
  );

  soa_page_queue #(
    .DEPTH (NUM_PAGES),
    .PIW   (PIW)
  ) u_partial_q (
    .clk   (clk),
    .rst   (rst),
    .ctl   (pq_ctl),
    .page  (pa_page),
    .head  (pq_head),
    .count (pq_cnt)
  );

  soa_page_queue #(
    .DEPTH (NUM_PAGES),
    .PIW   (PIW)
  ) u_empty_q (
    .clk   (clk),
    .rst   (rst),
    .ctl   (eq_ctl),
    .page  (pa_page),
    .head  (eq_head),
    .count (eq_cnt)
  );

  // moving a page pulls it from the queue of its old tag
  always_comb begin
    pq_ctl.remove = rq_en && (page_tag[pa_page] == soa_pkg::TAG_PARTIAL);
    pq_ctl.push   = rq_en && (rq_tag == soa_pkg::TAG_PARTIAL);
    eq_ctl.remove = rq_en && (page_tag[pa_page] == soa_pkg::TAG_EMPTY);
    eq_ctl.push   = rq_en && (rq_tag == soa_pkg::TAG_EMPTY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= soa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd_r_next    = cmd_r;
    grow_r_next   = grow_r;
    oaddr_next    = oaddr;
    pg_next       = pg;
    kk_next       = kk;
    n_r_next      = n_r;
    done_r_next   = 1'b0;
    status_r_next = status_r;
    raddr_next    = raddr;
    pa_page       = pg;
    pa_set        = 1'b0;
    pa_clr        = 1'b0;
    pc_we         = 1'b0;
    pc_wdata      = '0;
    rq_en         = 1'b0;
    rq_tag        = soa_pkg::TAG_NONE;
    oc_inc        = 1'b0;
    oc_dec        = 1'b0;
    u_start       = 1'b0;
    u_op          = soa_pkg::UOP_DIV;
    u_a           = AW'(SLAB_BYTES);
    st_we         = 1'b0;
    st_waddr      = {pg, kk};
    st_wdata      = kk;
    st_raddr      = {pg, KW'(cnt_cur - NW'(1))};
    fm_we         = 1'b0;
    fm_waddr      = {pg, kk};
    fm_wdata      = 1'b1;
    fm_raddr      = {pg, KW'(u_quo)};

    unique case (state)
      soa_pkg::S_IDLE: begin
        if (start) begin
          cmd_r_next  = cmd;
          grow_r_next = may_grow;
          oaddr_next  = object_addr;
          unique case (soa_pkg::cmd_t'(cmd))
            soa_pkg::CMD_ALLOC, soa_pkg::CMD_FREE: begin
              u_start    = 1'b1;
              state_next = soa_pkg::S_NDIV;
            end
            soa_pkg::CMD_REAP: begin
              done_r_next = 1'b1;
              if (eq_cnt == '0) begin
                status_r_next = soa_pkg::STAT_NO_REAP;
                raddr_next    = '0;
              end else begin
                pa_page       = eq_head;
                rq_en         = 1'b1;
                rq_tag        = soa_pkg::TAG_NONE;
                pa_clr        = 1'b1;
                pc_we         = 1'b1;
                pc_wdata      = '0;
                oc_dec        = 1'b1;
                status_r_next = soa_pkg::STAT_OK;
                raddr_next    = pool_base + soa_pkg::ADDR_W'({eq_head, {PGW{1'b0}}});
              end
            end
            default: begin
              done_r_next   = 1'b1;
              status_r_next = soa_pkg::STAT_OK;
              raddr_next    = '0;
            end
          endcase
        end
      end

      soa_pkg::S_NDIV: begin
        if (u_done) begin
          if (CMPW'(u_quo) > CMPW'(MAX_OBJS)) begin
            n_r_next = NW'(MAX_OBJS);
          end else begin
            n_r_next = NW'(u_quo);
          end
          state_next = (cmd_r == soa_pkg::CMD_ALLOC) ? soa_pkg::S_PICK : soa_pkg::S_FCHK;
        end
      end

      soa_pkg::S_PICK: begin
        if (pq_cnt != '0) begin
          pg_next    = pq_head;
          state_next = soa_pkg::S_SRD;
        end else if (eq_cnt != '0) begin
          pg_next    = eq_head;
          state_next = soa_pkg::S_SRD;
        end else if (grow_r && (n_r != '0)) begin
          pg_next    = '0;
          state_next = soa_pkg::S_SCAN;
        end else begin
          done_r_next   = 1'b1;
          status_r_next = soa_pkg::STAT_NO_MEM;
          raddr_next    = '0;
          state_next    = soa_pkg::S_IDLE;
        end
      end

      // lowest page not yet held
      soa_pkg::S_SCAN: begin
        if (!page_owned[pg]) begin
          kk_next    = '0;
          state_next = soa_pkg::S_FILL;
        end else if (pg == PIW'(NUM_PAGES - 1)) begin
          done_r_next   = 1'b1;
          status_r_next = soa_pkg::STAT_NO_MEM;
          raddr_next    = '0;
          state_next    = soa_pkg::S_IDLE;
        end else begin
          pg_next = pg + PIW'(1);
        end
      end

      // fill the stack so the highest object pops first
      soa_pkg::S_FILL: begin
        st_we  = 1'b1;
        fm_we  = 1'b1;
        if (NW'(kk) + NW'(1) == n_r) begin
          pa_set     = 1'b1;
          pc_we      = 1'b1;
          pc_wdata   = n_r;
          oc_inc     = 1'b1;
          rq_en      = 1'b1;
          rq_tag     = soa_pkg::TAG_EMPTY;
          state_next = soa_pkg::S_SRD;
        end else begin
          kk_next = kk + KW'(1);
        end
      end

      soa_pkg::S_SRD: begin
        if (cnt_cur == '0) begin
          done_r_next   = 1'b1;
          status_r_next = soa_pkg::STAT_NO_MEM;
          raddr_next    = '0;
          state_next    = soa_pkg::S_IDLE;
        end else begin
          state_next = soa_pkg::S_SWAIT;
        end
      end

      soa_pkg::S_SWAIT: begin
        kk_next  = st_rdata;
        fm_we    = 1'b1;
        fm_waddr = {pg, st_rdata};
        fm_wdata = 1'b0;
        pc_we    = 1'b1;
        pc_wdata = cnt_cur - NW'(1);
        if (cnt_cur == NW'(1)) begin
          rq_en  = 1'b1;
          rq_tag = soa_pkg::TAG_FULL;
        end else if (cnt_cur == n_r) begin
          rq_en  = 1'b1;
          rq_tag = soa_pkg::TAG_PARTIAL;
        end
        u_start    = 1'b1;
        u_op       = soa_pkg::UOP_MUL;
        u_a        = AW'(st_rdata);
        state_next = soa_pkg::S_MUL;
      end

      soa_pkg::S_MUL: begin
        if (u_done) begin
          done_r_next   = 1'b1;
          status_r_next = soa_pkg::STAT_OK;
          raddr_next    = pool_base + soa_pkg::ADDR_W'({pg, u_prod[PGW-1:0]});
          state_next    = soa_pkg::S_IDLE;
        end
      end

      soa_pkg::S_FCHK: begin
        if (rel[soa_pkg::ADDR_W] || (rel[soa_pkg::ADDR_W-1:0] >= SPAN)) begin
          done_r_next   = 1'b1;
          status_r_next = soa_pkg::STAT_BAD;
          raddr_next    = '0;
          state_next    = soa_pkg::S_IDLE;
        end else begin
          pg_next    = rel[PGW +: PIW];
          u_start    = 1'b1;
          u_op       = soa_pkg::UOP_DIV;
          u_a        = AW'(rel[PGW-1:0]);
          state_next = soa_pkg::S_FDIV;
        end
      end

      soa_pkg::S_FDIV: begin
        if (u_done) begin
          if (page_owned[pg] && (u_rem == '0) && (CMPW'(u_quo) < CMPW'(n_r))) begin
            kk_next    = KW'(u_quo);
            state_next = soa_pkg::S_FWAIT;
          end else begin
            done_r_next   = 1'b1;
            status_r_next = soa_pkg::STAT_BAD;
            raddr_next    = '0;
            state_next    = soa_pkg::S_IDLE;
          end
        end
      end

      soa_pkg::S_FWAIT: begin
        done_r_next = 1'b1;
        raddr_next  = '0;
        state_next  = soa_pkg::S_IDLE;
        if (fm_rdata) begin
          status_r_next = soa_pkg::STAT_DOUBLE;
        end else begin
          status_r_next = soa_pkg::STAT_OK;
          if (cnt_cur < n_r) begin
            st_we    = 1'b1;
            st_waddr = {pg, KW'(cnt_cur)};
            st_wdata = kk;
            fm_we    = 1'b1;
            fm_wdata = 1'b1;
            pc_we    = 1'b1;
            pc_wdata = cnt_cur + NW'(1);
            if (cnt_cur + NW'(1) == n_r) begin
              rq_en  = 1'b1;
              rq_tag = soa_pkg::TAG_EMPTY;
            end else if (cnt_cur == '0) begin
              rq_en  = 1'b1;
              rq_tag = soa_pkg::TAG_PARTIAL;
            end
          end
        end
      end

      default: begin
        state_next = soa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_r     <= 1'b0;
      owned_cnt  <= '0;
      page_owned <= '0;
      req_size   <= soa_pkg::REQ_W'(64);
      align_log2 <= soa_pkg::ALIGN_W'(3);
      pool_base  <= '0;
      for (int i = 0; i < NUM_PAGES; i++) begin
        page_tag[i] <= soa_pkg::TAG_NONE;
        page_cnt[i] <= '0;
      end
    end else begin
      done_r <= done_r_next;
      if (oc_inc) begin
        owned_cnt <= owned_cnt + CW'(1);
      end else if (oc_dec) begin
        owned_cnt <= owned_cnt - CW'(1);
      end
      if (pa_set) begin
        page_owned[pa_page] <= 1'b1;
      end else if (pa_clr) begin
        page_owned[pa_page] <= 1'b0;
      end
      if (pc_we) begin
        page_cnt[pa_page] <= pc_wdata;
      end
      if (rq_en) begin
        page_tag[pa_page] <= rq_tag;
      end
      // geometry is fixed while any page is held
      if (cfg_we && (owned_cnt == '0)) begin
        unique case (soa_pkg::cfg_reg_t'(cfg_idx))
          soa_pkg::REG_REQ_SIZE:  req_size   <= cfg_wdata[soa_pkg::REQ_W-1:0];
          soa_pkg::REG_ALIGN:     align_log2 <= cfg_wdata[soa_pkg::ALIGN_W-1:0];
          soa_pkg::REG_POOL_BASE: pool_base  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_r_next;
    grow_r   <= grow_r_next;
    oaddr    <= oaddr_next;
    pg       <= pg_next;
    kk       <= kk_next;
    n_r      <= n_r_next;
    status_r <= status_r_next;
    raddr    <= raddr_next;
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    st_rdata <= stack_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (fm_we) begin
      free_mem[fm_waddr] <= fm_wdata;
    end
    fm_rdata <= free_mem[fm_raddr];
  end

  assign busy        = (state != soa_pkg::S_IDLE);
  assign done        = done_r;
  assign status      = status_r;
  assign result_addr = raddr;
  assign bytes_held  = soa_pkg::HELD_W'({owned_cnt, {PGW{1'b0}}});

`ifndef SYNTH
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    owned_cnt == CW'($countones(page_owned)))
    else $error("held page count out of step with page flags");

  a_queues_fit: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(pq_cnt) + (CW+1)'(eq_cnt) <= (CW+1)'(owned_cnt))
    else $error("more queued slabs than held pages");

  a_item_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("accepted item neither finished nor in work");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while the block is busy");
`endif

endmodule

// ===== design/soa_shift_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_shift_unit
// Shared bit-serial unit: restoring divide or shift-add multiply, one bit a
// cycle, AW bits per operation.
// ----------------------------------------------------------------------------
module soa_shift_unit #(
  parameter int AW = 13,
  parameter int SW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  soa_pkg::uop_t     op,
  input  logic [AW-1:0]     a,
  input  logic [SW-1:0]     b,
  output logic              done,
  output logic [AW-1:0]     quo,
  output logic [SW-1:0]     rem,
  output logic [AW-1:0]     prod
);

  localparam int IW = $clog2(AW + 1);

  logic              busy;
  logic              done_r;
  soa_pkg::uop_t     op_r;
  logic [IW-1:0]     cnt;
  logic [AW-1:0]     sh;
  logic [AW+SW-1:0]  acc;
  logic [SW-1:0]     b_r;

  logic [SW:0]       trial;
  logic              ge;
  logic [AW+SW-1:0]  acc_next;
  logic [AW-1:0]     sh_next;

  always_comb begin
    trial = {acc[SW-1:0], sh[AW-1]};
    ge    = trial >= {1'b0, b_r};
    if (op_r == soa_pkg::UOP_DIV) begin
      acc_next = (AW+SW)'(ge ? (trial - {1'b0, b_r}) : trial);
      sh_next  = {sh[AW-2:0], ge};
    end else begin
      acc_next = (acc << 1) + (sh[AW-1] ? (AW+SW)'(b_r) : '0);
      sh_next  = sh << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= IW'(AW);
      end else if (busy) begin
        cnt <= cnt - IW'(1);
        if (cnt == IW'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= op;
      sh   <= a;
      b_r  <= b;
      acc  <= '0;
    end else if (busy) begin
      sh  <= sh_next;
      acc <= acc_next;
    end
  end

  assign done = done_r;
  assign quo  = sh;
  assign rem  = acc[SW-1:0];
  assign prod = acc[AW-1:0];

endmodule

// ===== design/soa_page_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_page_queue
// Ordered page queue: append at the tail, remove a page from any place with
// the entries behind it closing up. Entry 0 is the oldest.
// ----------------------------------------------------------------------------
module soa_page_queue #(
  parameter int DEPTH = 16,
  parameter int PIW   = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  soa_pkg::q_ctl_t             ctl,
  input  logic [PIW-1:0]              page,
  output logic [PIW-1:0]              head,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [PIW-1:0] q      [DEPTH];
  logic [PIW-1:0] q_next [DEPTH];
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cnt_rm;
  logic [CW-1:0]  cnt_next;
  logic [DEPTH-1:0] gone;
  logic           hit;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      hit     = hit | ((CW'(i) < cnt) && (q[i] == page));
      gone[i] = hit & ctl.remove;
    end
    cnt_rm = cnt - CW'(hit & ctl.remove);
    for (int i = 0; i < DEPTH; i++) begin
      if (i < DEPTH - 1) begin
        q_next[i] = gone[i] ? q[(i < DEPTH - 1) ? i + 1 : i] : q[i];
      end else begin
        q_next[i] = q[i];
      end
      if (ctl.push && (CW'(i) == cnt_rm)) begin
        q_next[i] = page;
      end
    end
    cnt_next = cnt_rm + CW'(ctl.push && (cnt_rm < CW'(DEPTH)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign head  = q[0];
  assign count = cnt;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for slab_object_allocator: directed table then
// randomized alloc/free/reap traffic over several cache geometries, each
// result checked against an in-bench model of the slab queues and stacks.
// ----------------------------------------------------------------------------
module testbench;
  import soa_pkg::*;

  localparam int NPG   = 16;
  localparam int PGB   = 4096;
  localparam int MAXO  = 512;
  localparam int HDRB  = 40;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] AMASK = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [ADDR_W-1:0]   addr;
    logic [HELD_W-1:0]   held;
  } slab_res_t;

  typedef struct {
    logic [CMD_W-1:0]  c;
    logic              g;
    logic [ADDR_W-1:0] a;
    bit                known;
    slab_res_t         r;
  } dir_row_t;

  logic clk, rst, start, busy, may_grow, done, cfg_we;
  logic [CMD_W-1:0] cmd;
  logic [ADDR_W-1:0] object_addr, result_addr, cfg_wdata;
  logic [STATUS_W-1:0] status;
  logic [HELD_W-1:0] bytes_held;
  logic [CFG_IDX_W-1:0] cfg_idx;

  slab_object_allocator dut (.*);

  // model state
  logic [REQ_W-1:0]   m_req;
  logic [ALIGN_W-1:0] m_align;
  logic [ADDR_W-1:0]  m_base;
  bit                 owned [NPG];
  tag_t               qtag [NPG];
  int                 fcnt [NPG];
  logic [8:0]         fstack [NPG][MAXO];
  bit                 isfree [NPG][MAXO];
  int                 partial_q[$], empty_q[$];
  int                 held;

  slab_res_t         pending[$];
  logic [ADDR_W-1:0] live[$], freed[$];
  int errors = 0, n_items = 0, n_results = 0, burst = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("slab_object_allocator: mismatch");
    $finish;
  end

  function automatic int osize();
    int s, a;
    s = (m_req < MIN_OBJ) ? MIN_OBJ : int'(m_req);
    a = 1 << m_align;
    return (s + a - 1) & ~(a - 1);
  endfunction

  function automatic int per_slab();
    int n;
    n = (PGB - HDRB) / osize();
    return (n > MAXO) ? MAXO : n;
  endfunction

  task automatic unqueue(int p);
    int i;
    if (qtag[p] == TAG_PARTIAL) begin
      i = 0;
      while (i < partial_q.size()) if (partial_q[i] == p) partial_q.delete(i); else i++;
    end else if (qtag[p] == TAG_EMPTY) begin
      i = 0;
      while (i < empty_q.size()) if (empty_q[i] == p) empty_q.delete(i); else i++;
    end
    qtag[p] = TAG_NONE;
  endtask

  task automatic requeue(int p, tag_t t);
    unqueue(p);
    qtag[p] = t;
    if (t == TAG_PARTIAL) partial_q.push_back(p);
    else if (t == TAG_EMPTY) empty_q.push_back(p);
  endtask

  task automatic grow_page(output bit ok);
    int n;
    n = per_slab();
    ok = 0;
    if (n == 0) return;
    for (int p = 0; p < NPG; p++) begin
      if (!owned[p]) begin
        for (int k = 0; k < n; k++) begin
          fstack[p][k] = 9'(k);
          isfree[p][k] = 1;
        end
        owned[p] = 1;
        fcnt[p] = n;
        held += PGB;
        requeue(p, TAG_EMPTY);
        ok = 1;
        return;
      end
    end
  endtask

  task automatic slab_predict(input logic [CMD_W-1:0] c, input logic g,
                              input logic [ADDR_W-1:0] a, output slab_res_t r);
    int p, k, n, s, cnt, off;
    bit have, ok;
    longint unsigned rel;
    n = per_slab();
    s = osize();
    r.st = STAT_OK;
    r.addr = '0;
    if (c == CMD_ALLOC) begin
      have = 1;
      p = 0;
      if (partial_q.size() > 0) p = partial_q[0];
      else if (empty_q.size() > 0) p = empty_q[0];
      else begin
        ok = 0;
        if (g) grow_page(ok);
        if (ok) p = empty_q[0];
        else have = 0;
      end
      if (!have || fcnt[p] == 0) r.st = STAT_NO_MEM;
      else begin
        cnt = fcnt[p];
        k = fstack[p][cnt-1];
        isfree[p][k] = 0;
        fcnt[p] = cnt - 1;
        if (cnt == 1) requeue(p, TAG_FULL);
        else if (cnt == n) requeue(p, TAG_PARTIAL);
        r.addr = (m_base + ADDR_W'(p * PGB) + ADDR_W'(k * s)) & AMASK;
        live.push_back(r.addr);
      end
    end else if (c == CMD_FREE) begin
      r.st = STAT_BAD;
      if (a >= m_base && (longint'(a) - longint'(m_base)) < NPG * PGB) begin
        rel = a - m_base;
        p = int'(rel / PGB);
        off = int'(rel % PGB);
        k = off / s;
        if (owned[p] && off % s == 0 && k < n) begin
          if (isfree[p][k]) r.st = STAT_DOUBLE;
          else begin
            r.st = STAT_OK;
            cnt = fcnt[p];
            foreach (live[i]) if (live[i] == a) begin live.delete(i); break; end
            freed.push_back(a);
            if (freed.size() > 8) void'(freed.pop_front());
            if (cnt < n) begin
              fstack[p][cnt] = 9'(k);
              isfree[p][k] = 1;
              fcnt[p] = cnt + 1;
              if (cnt + 1 == n) requeue(p, TAG_EMPTY);
              else if (cnt == 0) requeue(p, TAG_PARTIAL);
            end
          end
        end
      end
    end else if (c == CMD_REAP) begin
      if (empty_q.size() == 0) r.st = STAT_NO_REAP;
      else begin
        p = empty_q[0];
        unqueue(p);
        owned[p] = 0;
        fcnt[p] = 0;
        for (int j = 0; j < MAXO; j++) isfree[p][j] = 0;
        held -= PGB;
        r.addr = (m_base + ADDR_W'(p * PGB)) & AMASK;
      end
    end
    r.held = HELD_W'(held);
  endtask

  // drive one item and wait for it to be taken; start may stay high afterwards
  task automatic send(input logic [CMD_W-1:0] c, input logic g,
                      input logic [ADDR_W-1:0] a, input bit known = 0,
                      input slab_res_t kr = '0);
    slab_res_t r;
    start <= 1'b1;
    cmd <= c;
    may_grow <= g;
    object_addr <= a;
    do @(posedge clk); while (busy);
    slab_predict(c, g, a, r);
    pending.push_back(known ? kr : r);
    n_items++;
    if (burst > 0) burst--;
    else begin
      burst = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [ADDR_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (held == 0) begin
      case (idx)
        REG_REQ_SIZE: m_req = v[REQ_W-1:0];
        REG_ALIGN:    m_align = v[ALIGN_W-1:0];
        default:      m_base = v;
      endcase
    end
  endtask

  task automatic random_item();
    int sel;
    logic [ADDR_W-1:0] a;
    sel = $urandom_range(0, 99);
    if (sel < 42) send(CMD_ALLOC, $urandom_range(0, 9) != 0, {$urandom, $urandom});
    else if (sel < 82) begin
      if (sel < 64 && live.size() > 0) a = live[$urandom_range(0, live.size() - 1)];
      else if (sel < 70 && freed.size() > 0) a = freed[$urandom_range(0, freed.size() - 1)];
      else if (sel < 77) a = m_base + ADDR_W'($urandom_range(0, NPG * PGB + 300));
      else a = {$urandom, $urandom};
      send(CMD_FREE, $urandom_range(0, 1), a);
    end else if (sel < 94) send(CMD_REAP, $urandom_range(0, 1), {$urandom, $urandom});
    else send(CMD_UNUSED, $urandom_range(0, 1), {$urandom, $urandom});
  endtask

  // results: one strobe cycle each, compared against the oldest expectation
  always @(posedge clk) begin
    slab_res_t e;
    if (!rst && done) begin
      n_results++;
      if (pending.size() == 0) begin
        $error("result with nothing pending: status %0d", status);
        errors++;
      end else begin
        e = pending.pop_front();
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status);
          errors++;
        end
        if (result_addr !== e.addr) begin
          $error("result_addr exp %h got %h", e.addr, result_addr);
          errors++;
        end
        if (bytes_held !== e.held) begin
          $error("bytes_held exp %0d got %0d", e.held, bytes_held);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t dir [$];
    logic [REQ_W-1:0]   ph_req [7];
    logic [ALIGN_W-1:0] ph_al [7];
    logic [ADDR_W-1:0]  ph_base [7];
    rst = 1;
    start = 0;
    cmd = CMD_ALLOC;
    may_grow = 0;
    object_addr = '0;
    cfg_we = 0;
    cfg_idx = REG_REQ_SIZE;
    cfg_wdata = '0;
    m_req = 64;
    m_align = 3;
    m_base = '0;
    held = 0;
    foreach (owned[p]) begin
      owned[p] = 0;
      qtag[p] = TAG_NONE;
      fcnt[p] = 0;
      for (int j = 0; j < MAXO; j++) begin
        isfree[p][j] = 0;
        fstack[p][j] = '0;
      end
    end
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset geometry: 64-byte objects, 63 per slab, pool at 0
    dir = '{
      '{CMD_ALLOC,  0, 48'h0,      1, '{STAT_NO_MEM,  48'h0,   17'd0}},
      '{CMD_REAP,   1, 48'h0,      1, '{STAT_NO_REAP, 48'h0,   17'd0}},
      '{CMD_FREE,   0, 48'h0,      1, '{STAT_BAD,     48'h0,   17'd0}},
      '{CMD_UNUSED, 1, AMASK,      1, '{STAT_OK,      48'h0,   17'd0}},
      '{CMD_ALLOC,  1, 48'h0,      1, '{STAT_OK,      48'hF80, 17'd4096}},
      '{CMD_FREE,   0, 48'hF80,    1, '{STAT_OK,      48'h0,   17'd4096}},
      '{CMD_FREE,   0, 48'hF80,    1, '{STAT_DOUBLE,  48'h0,   17'd4096}},
      '{CMD_FREE,   0, 48'hF81,    1, '{STAT_BAD,     48'h0,   17'd4096}},
      '{CMD_FREE,   1, AMASK,      1, '{STAT_BAD,     48'h0,   17'd4096}},
      '{CMD_FREE,   0, 48'hFC0,    1, '{STAT_BAD,     48'h0,   17'd4096}},
      '{CMD_REAP,   0, 48'h0,      1, '{STAT_OK,      48'h0,   17'd0}},
      '{CMD_ALLOC,  1, 48'h0,      0, '0},
      '{CMD_ALLOC,  0, 48'h0,      0, '0},
      '{CMD_ALLOC,  1, 48'h0,      0, '0},
      '{CMD_FREE,   0, 48'hF40,    0, '0},
      '{CMD_FREE,   0, 48'hF80,    0, '0},
      '{CMD_FREE,   0, 48'hF00,    0, '0},
      '{CMD_REAP,   0, 48'h0,      0, '0},
      '{CMD_FREE,   0, 48'h10000,  0, '0},
      '{CMD_REAP,   0, 48'h0,      0, '0}
    };
    foreach (dir[i]) send(dir[i].c, dir[i].g, dir[i].a, dir[i].known, dir[i].r);
    quiesce();

    // geometries: smallest object, single-object slab, too large, widest fields
    ph_req  = '{12'd1, 12'd4056, 12'd4056, 12'hFFF, 12'd100, 12'd8, 12'd24};
    ph_al   = '{4'd0, 4'd0, 4'd11, 4'hF, 4'd5, 4'd0, 4'd3};
    ph_base = '{48'h0, 48'hFFFF_FFFF_0000, 48'h1000, AMASK, 48'hABCD_E000,
                {$urandom, $urandom}, 48'h5555_5555_5000};
    for (int ph = 0; ph < 7; ph++) begin
      cfg_write(REG_REQ_SIZE, {$urandom, $urandom} & ~48'hFFF | ph_req[ph]);
      cfg_write(REG_ALIGN, ph_al[ph]);
      cfg_write(REG_POOL_BASE, ph_base[ph]);
      for (int i = 0; i < 150; i++) random_item();
      quiesce();
      // written while pages may be held: dropped if any are
      cfg_write(REG_REQ_SIZE, 48'h0);
      // drain: free everything still out, then hand back all pages
      while (live.size() > 0) send(CMD_FREE, 0, live[0]);
      while (held != 0) send(CMD_REAP, 0, 48'h0);
      quiesce();
    end

    $display("ran %0d items over 8 cache geometries, %0d results checked",
             n_items, n_results);
    if (errors == 0 && pending.size() == 0)
      $display("slab_object_allocator: match");
    else
      $display("slab_object_allocator: mismatch");
    $finish;
  end

endmodule

// ===== slab_object_allocator.f =====
design/soa_pkg.sv
design/soa_shift_unit.sv
design/soa_page_queue.sv
design/slab_object_allocator.sv
tb/sv/testbench.sv
